/* design/spi_flash_command_sequencer_assert.svh */
// Assertion macros for the SPI flash command sequencer checker.
// Depends on nothing; included by the checker file only.
`ifndef SPI_FLASH_COMMAND_SEQUENCER_ASSERT_SVH
`define SPI_FLASH_COMMAND_SEQUENCER_ASSERT_SVH

// Check cons in the same cycle as ante.
`define SFCS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sfcs assertion failed");

// Check cons in the cycle after ante.
`define SFCS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sfcs assertion failed");

`endif

/* design/sfcs_pkg.sv */
// Shared types, codes and constants of the SPI flash command sequencer.
// Depends on nothing; imported by every module of the block.
package sfcs_pkg;

    localparam int PAGE_BYTES_DEFAULT   = 256;
    localparam int ADDRESS_BITS_DEFAULT = 24;
    localparam int QUEUE_DEPTH_DEFAULT  = 2;

    localparam int FLASH_ADDR_W = 24;
    localparam int LEN_W        = 25;
    localparam logic [LEN_W-1:0] MAX_LEN = 25'h100_0000;

    localparam logic [2:0] MODE_BEGIN_READ  = 3'd0;
    localparam logic [2:0] MODE_READ_BYTE   = 3'd1;
    localparam logic [2:0] MODE_BEGIN_PROG  = 3'd2;
    localparam logic [2:0] MODE_STATUS      = 3'd3;
    localparam logic [2:0] MODE_PROG_BYTE   = 3'd4;
    localparam logic [2:0] MODE_BEGIN_ERASE = 3'd5;

    localparam logic [7:0] CMD_WREN  = 8'h06;
    localparam logic [7:0] CMD_RDSR  = 8'h05;
    localparam logic [7:0] CMD_PP    = 8'h02;
    localparam logic [7:0] CMD_READ  = 8'h03;
    localparam logic [7:0] CMD_BE    = 8'hD8;
    localparam logic [7:0] DUMMY     = 8'h00;

    localparam logic [1:0] CAP_IGNORE = 2'd0;
    localparam logic [1:0] CAP_STATUS = 2'd1;
    localparam logic [1:0] CAP_DATA   = 2'd2;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_READ  = 3'd1,
        PH_PPOLL = 3'd2,
        PH_PDATA = 3'd3,
        PH_EPOLL = 3'd4
    } phase_t;

    typedef enum logic [2:0] {
        JOB_ERROR      = 3'd0,
        JOB_READ_START = 3'd1,
        JOB_READ_BYTE  = 3'd2,
        JOB_POLL       = 3'd3,
        JOB_WREN_PROG  = 3'd4,
        JOB_WREN_ERASE = 3'd5,
        JOB_PROG_BYTE  = 3'd6,
        JOB_PROG_PAGE  = 3'd7
    } job_kind_t;

    typedef struct packed {
        job_kind_t               kind;
        logic [FLASH_ADDR_W-1:0] addr;
        logic [7:0]              data;
        logic                    fin;
    } job_t;

    typedef struct packed {
        logic [2:0]              mode;
        logic [FLASH_ADDR_W-1:0] address;
        logic [LEN_W-1:0]        length;
        logic [7:0]              write_data;
        logic [7:0]              status_value;
    } req_item_t;

    typedef struct packed {
        logic [7:0] spi_byte;
        logic [1:0] capture_kind;
        logic       release_cs;
        logic       op_done;
        logic       error_flag;
        logic       last_of_run;
    } rsp_item_t;

endpackage

/* design/sfcs_queue.sv */
// Short job queue between the front and back parts of the sequencer.
// Depends on sfcs_pkg for the job type.
module sfcs_queue
    import sfcs_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  job_t push_job,
    output logic pop_valid,
    input  logic pop,
    output job_t pop_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wptr_reg;
    logic [PTR_W-1:0] rptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = entry_reg[rptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wptr_reg <= (wptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rptr_reg <= (rptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wptr_reg] <= push_job;
        end
    end

endmodule

/* design/sfcs_front.sv */
// Front part: accepts requests, checks them against the phase, keeps the
// operation state and issues jobs. Uses sfcs_pkg.
module sfcs_front
    import sfcs_pkg::*;
#(
    parameter int PAGE_BYTES   = PAGE_BYTES_DEFAULT,
    parameter int ADDRESS_BITS = ADDRESS_BITS_DEFAULT
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  req_item_t req,
    output logic      push_valid,
    input  logic      push_ready,
    output job_t      push_job
);

    localparam int OFS_W = $clog2(PAGE_BYTES);
    localparam int PBL_W = $clog2(PAGE_BYTES + 1);

    phase_t                  phase_reg, phase_next;
    logic [ADDRESS_BITS-1:0] addr_reg, addr_next;
    logic [LEN_W-1:0]        bytes_reg, bytes_next;
    logic [PBL_W-1:0]        pbl_reg, pbl_next;

    logic                    accept;
    logic [LEN_W-1:0]        len_c;
    logic [ADDRESS_BITS-1:0] addr_c;
    logic [ADDRESS_BITS-1:0] addr_inc;
    logic [LEN_W-1:0]        bytes_dec;
    logic [PBL_W-1:0]        pbl_dec;
    logic [PBL_W-1:0]        room;

    assign req_ready  = push_ready;
    assign push_valid = req_valid;
    assign accept     = req_valid && req_ready;

    assign len_c      = req.length[LEN_W-1] ? MAX_LEN : req.length;
    assign addr_c     = req.address[ADDRESS_BITS-1:0];
    assign addr_inc   = addr_reg + 1'b1;
    assign bytes_dec  = bytes_reg - 1'b1;
    assign pbl_dec    = pbl_reg - 1'b1;
    assign room       = PBL_W'(PAGE_BYTES) - PBL_W'(addr_reg[OFS_W-1:0]);

    always_comb
    begin
        phase_next     = phase_reg;
        addr_next      = addr_reg;
        bytes_next     = bytes_reg;
        pbl_next       = pbl_reg;
        push_job.kind  = JOB_ERROR;
        push_job.addr  = FLASH_ADDR_W'(addr_reg);
        push_job.data  = req.write_data;
        push_job.fin   = 1'b0;

        case (req.mode)
            MODE_BEGIN_READ:
            begin
                if (phase_reg == PH_IDLE && len_c != '0)
                begin
                    push_job.kind = JOB_READ_START;
                    push_job.addr = FLASH_ADDR_W'(addr_c);
                    if (accept)
                    begin
                        addr_next  = addr_c;
                        bytes_next = len_c;
                        phase_next = PH_READ;
                    end
                end
            end
            MODE_READ_BYTE:
            begin
                if (phase_reg == PH_READ)
                begin
                    push_job.kind = JOB_READ_BYTE;
                    push_job.fin  = (bytes_dec == '0);
                    if (accept)
                    begin
                        bytes_next = bytes_dec;
                        addr_next  = addr_inc;
                        if (bytes_dec == '0)
                        begin
                            phase_next = PH_IDLE;
                        end
                    end
                end
            end
            MODE_BEGIN_PROG:
            begin
                if (phase_reg == PH_IDLE && len_c != '0)
                begin
                    push_job.kind = JOB_POLL;
                    if (accept)
                    begin
                        addr_next  = addr_c;
                        bytes_next = len_c;
                        phase_next = PH_PPOLL;
                    end
                end
            end
            MODE_BEGIN_ERASE:
            begin
                if (phase_reg == PH_IDLE)
                begin
                    push_job.kind = JOB_POLL;
                    if (accept)
                    begin
                        addr_next  = addr_c;
                        phase_next = PH_EPOLL;
                    end
                end
            end
            MODE_STATUS:
            begin
                if (phase_reg inside {PH_PPOLL, PH_EPOLL})
                begin
                    if (req.status_value[0])
                    begin
                        push_job.kind = JOB_POLL;
                    end
                    else if (phase_reg == PH_EPOLL)
                    begin
                        push_job.kind = JOB_WREN_ERASE;
                        if (accept)
                        begin
                            phase_next = PH_IDLE;
                        end
                    end
                    else
                    begin
                        push_job.kind = JOB_WREN_PROG;
                        if (accept)
                        begin
                            phase_next = PH_PDATA;
                            pbl_next   = (bytes_reg < LEN_W'(room)) ?
                                         bytes_reg[PBL_W-1:0] : room;
                        end
                    end
                end
            end
            MODE_PROG_BYTE:
            begin
                if (phase_reg == PH_PDATA)
                begin
                    if (bytes_dec == '0)
                    begin
                        push_job.kind = JOB_PROG_BYTE;
                        push_job.fin  = 1'b1;
                    end
                    else if (pbl_dec == '0)
                    begin
                        push_job.kind = JOB_PROG_PAGE;
                    end
                    else
                    begin
                        push_job.kind = JOB_PROG_BYTE;
                    end
                    if (accept)
                    begin
                        bytes_next  = bytes_dec;
                        addr_next   = addr_inc;
                        pbl_next    = pbl_dec;
                        if (bytes_dec == '0)
                        begin
                            phase_next = PH_IDLE;
                            pbl_next   = '0;
                        end
                        else if (pbl_dec == '0)
                        begin
                            phase_next = PH_PPOLL;
                        end
                    end
                end
            end
            default:
            begin
                push_job.kind = JOB_ERROR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            addr_reg      <= '0;
            bytes_reg     <= '0;
            pbl_reg       <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            addr_reg      <= addr_next;
            bytes_reg     <= bytes_next;
            pbl_reg       <= pbl_next;
        end
    end

endmodule

/* design/sfcs_back.sv */
// Back part: expands each queued job into its SPI byte frames, one result
// per cycle into the output register while rsp_ready does not hold it. Uses sfcs_pkg.
module sfcs_back
    import sfcs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      job_valid,
    input  job_t      job,
    output logic      job_pop,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output rsp_item_t rsp
);

    logic [2:0] step_reg;
    logic [2:0] last_step;
    logic       last;
    logic       load;
    logic       out_valid_reg;
    rsp_item_t  out_reg;
    rsp_item_t  gen;
    logic [7:0] addr_byte;

    assign load      = job_valid && (!out_valid_reg || rsp_ready);
    assign job_pop   = load && last;
    assign last      = (step_reg == last_step);
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    always_comb
    begin
        case (job.kind)
            JOB_READ_START: last_step = 3'd3;
            JOB_POLL:       last_step = 3'd1;
            JOB_WREN_PROG:  last_step = 3'd4;
            JOB_WREN_ERASE: last_step = 3'd4;
            JOB_PROG_PAGE:  last_step = 3'd2;
            default:        last_step = 3'd0;
        endcase
    end

    always_comb
    begin
        case (step_reg - last_step + 3'd2)
            3'd0:    addr_byte = job.addr[23:16];
            3'd1:    addr_byte = job.addr[15:8];
            default: addr_byte = job.addr[7:0];
        endcase
    end

    always_comb
    begin
        gen = '0;
        case (job.kind)
            JOB_ERROR:
            begin
                gen.error_flag = 1'b1;
            end
            JOB_READ_START:
            begin
                gen.spi_byte = (step_reg == 3'd0) ? CMD_READ : addr_byte;
            end
            JOB_READ_BYTE:
            begin
                gen.spi_byte     = DUMMY;
                gen.capture_kind = CAP_DATA;
                gen.release_cs   = job.fin;
                gen.op_done      = job.fin;
            end
            JOB_POLL:
            begin
                if (step_reg == 3'd0)
                begin
                    gen.spi_byte = CMD_RDSR;
                end
                else
                begin
                    gen.spi_byte     = DUMMY;
                    gen.capture_kind = CAP_STATUS;
                    gen.release_cs   = 1'b1;
                end
            end
            JOB_WREN_PROG, JOB_WREN_ERASE:
            begin
                if (step_reg == 3'd0)
                begin
                    gen.spi_byte   = CMD_WREN;
                    gen.release_cs = 1'b1;
                end
                else if (step_reg == 3'd1)
                begin
                    gen.spi_byte = (job.kind == JOB_WREN_ERASE) ? CMD_BE : CMD_PP;
                end
                else
                begin
                    gen.spi_byte = addr_byte;
                    if (job.kind == JOB_WREN_ERASE && last)
                    begin
                        gen.release_cs = 1'b1;
                        gen.op_done    = 1'b1;
                    end
                end
            end
            JOB_PROG_BYTE:
            begin
                gen.spi_byte   = job.data;
                gen.release_cs = job.fin;
                gen.op_done    = job.fin;
            end
            JOB_PROG_PAGE:
            begin
                if (step_reg == 3'd0)
                begin
                    gen.spi_byte   = job.data;
                    gen.release_cs = 1'b1;
                end
                else if (step_reg == 3'd1)
                begin
                    gen.spi_byte = CMD_RDSR;
                end
                else
                begin
                    gen.spi_byte     = DUMMY;
                    gen.capture_kind = CAP_STATUS;
                    gen.release_cs   = 1'b1;
                end
            end
            default:
            begin
                gen.error_flag = 1'b1;
            end
        endcase
        gen.last_of_run = last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
                step_reg      <= last ? 3'd0 : step_reg + 3'd1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg <= gen;
        end
    end

endmodule

/* design/spi_flash_command_sequencer.sv */
// SPI flash command sequencer: one request enters per cycle while the job
// queue has room; results leave one per cycle from the output register while
// rsp_ready takes them. A request yields 1 to 5 results (a poll 2, a read
// start 4, a write-enable frame 5, a page end 3, data bytes 1). PAGE_BYTES must
// be a power of two: the page offset of an address is its low address bits.
// Top level: front, job queue and back; uses sfcs_pkg.
module spi_flash_command_sequencer
    import sfcs_pkg::*;
#(
    parameter int PAGE_BYTES   = PAGE_BYTES_DEFAULT,
    parameter int ADDRESS_BITS = ADDRESS_BITS_DEFAULT,
    parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEFAULT
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  req_item_t req,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output rsp_item_t rsp
);

    logic push_valid;
    logic push_ready;
    job_t push_job;
    logic pop_valid;
    logic pop;
    job_t pop_job;

    sfcs_front #(
        .PAGE_BYTES   (PAGE_BYTES),
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job)
    );

    sfcs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_job    (pop_job)
    );

    sfcs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (pop_valid),
        .job       (pop_job),
        .job_pop   (pop),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

/* design/sfcs_checker.sv */
// Port-level checker for the SPI flash command sequencer, bound to the top.
// Depends on sfcs_pkg and spi_flash_command_sequencer_assert.svh.
`include "spi_flash_command_sequencer_assert.svh"

module sfcs_checker
    import sfcs_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      req_valid,
    input logic      req_ready,
    input req_item_t req,
    input logic      rsp_valid,
    input logic      rsp_ready,
    input rsp_item_t rsp
);

    logic error_clean;
    logic done_clean;
    logic status_clean;

    assign error_clean  = (rsp.spi_byte == 8'h00) && (rsp.capture_kind == CAP_IGNORE) &&
                          !rsp.release_cs && !rsp.op_done && rsp.last_of_run;
    assign done_clean   = rsp.release_cs && rsp.last_of_run && !rsp.error_flag;
    assign status_clean = (rsp.spi_byte == DUMMY) && rsp.release_cs && !rsp.op_done;

    `SFCS_ASSERT_NEXT(a_req_hold, clk, rst_n, req_valid && !req_ready, req_valid && $stable(req))

    `SFCS_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))

    `SFCS_ASSERT_SAME(a_error_clean, clk, rst_n, rsp_valid && rsp.error_flag, error_clean)

    `SFCS_ASSERT_SAME(a_done_ends_frame, clk, rst_n, rsp_valid && rsp.op_done, done_clean)

    `SFCS_ASSERT_SAME(a_status_capture, clk, rst_n, rsp_valid && rsp.capture_kind == CAP_STATUS, status_clean)

endmodule

bind spi_flash_command_sequencer sfcs_checker u_sfcs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

/* tb/spi_flash_command_sequencer_tb.sv */
// Self-checking testbench for the SPI flash command sequencer: directed table, then
// random read, program and erase sequences with random stalls on both channels.
// Depends on sfcs_pkg and spi_flash_command_sequencer.
module spi_flash_command_sequencer_tb;
    import sfcs_pkg::*;

    localparam logic [2:0] MODE_UNUSED_6 = 3'd6;
    localparam logic [2:0] MODE_UNUSED_7 = 3'd7;
    localparam int RANDOM_REQUESTS = 150;
    localparam int STALL_LIMIT     = 2000;
    localparam int HOLD_OFF_CYCLES = 300;

    localparam rsp_item_t REJECT = '{spi_byte: 8'h00, capture_kind: CAP_IGNORE,
                                     release_cs: 1'b0, op_done: 1'b0,
                                     error_flag: 1'b1, last_of_run: 1'b1};

    typedef struct packed {
        req_item_t       req;
        logic [2:0]      n_typed;
        rsp_item_t [3:0] typed;
    } step_row_t;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      req_valid;
    logic      req_ready;
    req_item_t req;
    logic      rsp_valid;
    logic      rsp_ready;
    rsp_item_t rsp;

    phase_t            flash_phase = PH_IDLE;
    logic [23:0]       flash_addr = '0;
    logic [LEN_W-1:0]  bytes_owed = '0;
    logic [8:0]        page_room_left = '0;

    rsp_item_t frames[$];
    rsp_item_t due_frames[$];
    step_row_t script[$];

    int requests_sent = 0;
    int requests_rejected = 0;
    int ops_finished = 0;
    int frames_checked = 0;
    int mismatches = 0;
    int stall_cycles = 0;

    spi_flash_command_sequencer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic rsp_item_t spi_frame(input logic [7:0] b, input logic [1:0] cap,
                                            input logic rel, input logic done,
                                            input logic err, input logic last);
        rsp_item_t f;
        f.spi_byte     = b;
        f.capture_kind = cap;
        f.release_cs   = rel;
        f.op_done      = done;
        f.error_flag   = err;
        f.last_of_run  = last;
        return f;
    endfunction

    function automatic string frame_text(input rsp_item_t f);
        return $sformatf("byte %h cap %0d rel %b done %b err %b last %b",
                         f.spi_byte, f.capture_kind, f.release_cs,
                         f.op_done, f.error_flag, f.last_of_run);
    endfunction

    function automatic step_row_t step_row(input logic [2:0] m, input logic [23:0] a,
                                           input logic [LEN_W-1:0] l, input logic [7:0] w,
                                           input logic [7:0] s, input int n = 0,
                                           input rsp_item_t t0 = '0, input rsp_item_t t1 = '0,
                                           input rsp_item_t t2 = '0, input rsp_item_t t3 = '0);
        step_row_t r;
        r.req.mode         = m;
        r.req.address      = a;
        r.req.length       = l;
        r.req.write_data   = w;
        r.req.status_value = s;
        r.n_typed          = 3'(n);
        r.typed            = {t3, t2, t1, t0};
        return r;
    endfunction

    task automatic put_poll();
        frames.push_back(spi_frame(CMD_RDSR, CAP_IGNORE, 1'b0, 1'b0, 1'b0, 1'b0));
        frames.push_back(spi_frame(DUMMY, CAP_STATUS, 1'b1, 1'b0, 1'b0, 1'b0));
    endtask

    task automatic put_cmd_addr(input logic [7:0] cmd, input logic [23:0] a,
                                input logic rel, input logic done);
        frames.push_back(spi_frame(cmd, CAP_IGNORE, 1'b0, 1'b0, 1'b0, 1'b0));
        frames.push_back(spi_frame(a[23:16], CAP_IGNORE, 1'b0, 1'b0, 1'b0, 1'b0));
        frames.push_back(spi_frame(a[15:8], CAP_IGNORE, 1'b0, 1'b0, 1'b0, 1'b0));
        frames.push_back(spi_frame(a[7:0], CAP_IGNORE, rel, done, 1'b0, 1'b0));
    endtask

    task automatic sequence_frames(input req_item_t r);
        logic [LEN_W-1:0] len;
        int               room;
        rsp_item_t        tail;
        frames.delete();
        len = (r.length > MAX_LEN) ? MAX_LEN : r.length;
        if (r.mode == MODE_BEGIN_READ && flash_phase == PH_IDLE && len != '0)
        begin
            flash_addr  = r.address;
            bytes_owed  = len;
            flash_phase = PH_READ;
            put_cmd_addr(CMD_READ, r.address, 1'b0, 1'b0);
        end
        else if (r.mode == MODE_READ_BYTE && flash_phase == PH_READ)
        begin
            bytes_owed = bytes_owed - 1'b1;
            flash_addr = flash_addr + 1'b1;
            if (bytes_owed == '0)
            begin
                flash_phase = PH_IDLE;
                frames.push_back(spi_frame(DUMMY, CAP_DATA, 1'b1, 1'b1, 1'b0, 1'b0));
            end
            else
            begin
                frames.push_back(spi_frame(DUMMY, CAP_DATA, 1'b0, 1'b0, 1'b0, 1'b0));
            end
        end
        else if (r.mode == MODE_BEGIN_PROG && flash_phase == PH_IDLE && len != '0)
        begin
            flash_addr  = r.address;
            bytes_owed  = len;
            flash_phase = PH_PPOLL;
            put_poll();
        end
        else if (r.mode == MODE_BEGIN_ERASE && flash_phase == PH_IDLE)
        begin
            flash_addr  = r.address;
            flash_phase = PH_EPOLL;
            put_poll();
        end
        else if (r.mode == MODE_STATUS && (flash_phase == PH_PPOLL || flash_phase == PH_EPOLL))
        begin
            if (r.status_value[0])
            begin
                put_poll();
            end
            else
            begin
                frames.push_back(spi_frame(CMD_WREN, CAP_IGNORE, 1'b1, 1'b0, 1'b0, 1'b0));
                if (flash_phase == PH_EPOLL)
                begin
                    flash_phase = PH_IDLE;
                    put_cmd_addr(CMD_BE, flash_addr, 1'b1, 1'b1);
                end
                else
                begin
                    room = PAGE_BYTES_DEFAULT - int'(flash_addr % PAGE_BYTES_DEFAULT);
                    page_room_left = (int'(bytes_owed) < room) ? 9'(bytes_owed) : 9'(room);
                    flash_phase = PH_PDATA;
                    put_cmd_addr(CMD_PP, flash_addr, 1'b0, 1'b0);
                end
            end
        end
        else if (r.mode == MODE_PROG_BYTE && flash_phase == PH_PDATA)
        begin
            bytes_owed     = bytes_owed - 1'b1;
            page_room_left = page_room_left - 1'b1;
            flash_addr     = flash_addr + 1'b1;
            if (bytes_owed == '0)
            begin
                flash_phase    = PH_IDLE;
                page_room_left = '0;
                frames.push_back(spi_frame(r.write_data, CAP_IGNORE, 1'b1, 1'b1, 1'b0, 1'b0));
            end
            else if (page_room_left == '0)
            begin
                flash_phase = PH_PPOLL;
                frames.push_back(spi_frame(r.write_data, CAP_IGNORE, 1'b1, 1'b0, 1'b0, 1'b0));
                put_poll();
            end
            else
            begin
                frames.push_back(spi_frame(r.write_data, CAP_IGNORE, 1'b0, 1'b0, 1'b0, 1'b0));
            end
        end
        else
        begin
            frames.push_back(spi_frame(8'h00, CAP_IGNORE, 1'b0, 1'b0, 1'b1, 1'b0));
            requests_rejected++;
        end
        tail = frames.pop_back();
        tail.last_of_run = 1'b1;
        if (tail.op_done)
            ops_finished++;
        frames.push_back(tail);
    endtask

    function automatic req_item_t next_request(input bit noisy);
        req_item_t r;
        int        pick;
        r.mode         = MODE_READ_BYTE;
        r.address      = 24'($urandom);
        r.length       = 25'($urandom);
        r.write_data   = 8'($urandom);
        r.status_value = 8'($urandom);
        if (noisy && $urandom_range(0, 99) < 15)
        begin
            r.mode = 3'($urandom_range(0, 7));
            if (flash_phase == PH_IDLE && (r.mode == MODE_BEGIN_READ || r.mode == MODE_BEGIN_PROG))
                r.length = '0;
            return r;
        end
        case (flash_phase)
            PH_IDLE:
            begin
                pick = $urandom_range(0, 99);
                if (pick < 35)
                begin
                    r.mode   = MODE_BEGIN_READ;
                    r.length = 25'($urandom_range(1, 8));
                end
                else if (pick < 80)
                begin
                    r.mode   = MODE_BEGIN_PROG;
                    r.length = 25'($urandom_range(1, 20));
                    if ($urandom_range(0, 1) == 1)
                        r.address[7:0] = 8'($urandom_range(240, 255));
                end
                else
                begin
                    r.mode = MODE_BEGIN_ERASE;
                end
            end
            PH_READ:
                r.mode = MODE_READ_BYTE;
            PH_PPOLL, PH_EPOLL:
            begin
                r.mode            = MODE_STATUS;
                r.status_value[0] = ($urandom_range(0, 99) < 30);
            end
            default:
                r.mode = MODE_PROG_BYTE;
        endcase
        return r;
    endfunction

    task automatic issue(input step_row_t rw);
        int unsigned gap;
        gap = (((requests_sent / 24) % 4) == 3) ? 0 : $urandom_range(0, 16);
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req       <= rw.req;
        req_valid <= 1'b1;
        do @(posedge clk); while (!req_ready);
        sequence_frames(rw.req);
        if (rw.n_typed != '0)
        begin
            for (int i = 0; i < int'(rw.n_typed); i++)
                due_frames.push_back(rw.typed[i]);
        end
        else
        begin
            foreach (frames[i])
                due_frames.push_back(frames[i]);
        end
        requests_sent++;
    endtask

    initial
    begin
        int unsigned wait_cycles;
        rsp_item_t   want;
        bit          held;
        held = 1'b0;
        rsp_ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            wait_cycles = (((frames_checked / 30) % 4) == 1) ? 0 : $urandom_range(0, 16);
            if (!held && frames_checked >= 60)
            begin
                held        = 1'b1;
                wait_cycles = HOLD_OFF_CYCLES;
            end
            if (wait_cycles != 0)
            begin
                rsp_ready <= 1'b0;
                repeat (wait_cycles) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            do @(posedge clk); while (!rsp_valid);
            if (due_frames.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected frame: expected none, got %s",
                         $time, frame_text(rsp));
            end
            else
            begin
                want = due_frames.pop_front();
                if (rsp.spi_byte !== want.spi_byte || rsp.capture_kind !== want.capture_kind ||
                    rsp.release_cs !== want.release_cs || rsp.op_done !== want.op_done ||
                    rsp.error_flag !== want.error_flag || rsp.last_of_run !== want.last_of_run)
                begin
                    mismatches++;
                    $display("%0t: frame mismatch: expected %s, got %s",
                             $time, frame_text(want), frame_text(rsp));
                end
            end
            frames_checked++;
        end
    end

    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles == STALL_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles, %0d frames still due",
                     $time, STALL_LIMIT, due_frames.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        int base;
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req       <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        script.push_back(step_row(MODE_READ_BYTE, 24'h000000, 25'd0, 8'h00, 8'h00, 1, REJECT));
        script.push_back(step_row(MODE_STATUS, 24'h000000, 25'd0, 8'h00, 8'hFF, 1, REJECT));
        script.push_back(step_row(MODE_PROG_BYTE, 24'h000000, 25'd0, 8'hFF, 8'h00, 1, REJECT));
        script.push_back(step_row(MODE_UNUSED_6, 24'hFFFFFF, 25'h1FF_FFFF, 8'hFF, 8'hFF, 1,
                                  REJECT));
        script.push_back(step_row(MODE_UNUSED_7, 24'h000000, 25'd1, 8'h00, 8'h00, 1, REJECT));
        script.push_back(step_row(MODE_BEGIN_READ, 24'hFFFFFF, 25'd0, 8'h00, 8'h00, 1, REJECT));
        script.push_back(step_row(MODE_BEGIN_PROG, 24'h123456, 25'd0, 8'h00, 8'h00, 1, REJECT));
        script.push_back(step_row(MODE_BEGIN_READ, 24'hFFFFFF, 25'd2, 8'h00, 8'h00, 4,
                                  spi_frame(CMD_READ, CAP_IGNORE, 1'b0, 1'b0, 1'b0, 1'b0),
                                  spi_frame(8'hFF, CAP_IGNORE, 1'b0, 1'b0, 1'b0, 1'b0),
                                  spi_frame(8'hFF, CAP_IGNORE, 1'b0, 1'b0, 1'b0, 1'b0),
                                  spi_frame(8'hFF, CAP_IGNORE, 1'b0, 1'b0, 1'b0, 1'b1)));
        script.push_back(step_row(MODE_BEGIN_ERASE, 24'h000000, 25'd0, 8'h00, 8'h00, 1, REJECT));
        script.push_back(step_row(MODE_READ_BYTE, 24'h000000, 25'd0, 8'h00, 8'h00));
        script.push_back(step_row(MODE_READ_BYTE, 24'h000000, 25'd0, 8'h00, 8'h00, 1,
                                  spi_frame(DUMMY, CAP_DATA, 1'b1, 1'b1, 1'b0, 1'b1)));
        script.push_back(step_row(MODE_BEGIN_ERASE, 24'h000000, 25'd0, 8'h00, 8'h00));
        script.push_back(step_row(MODE_STATUS, 24'h000000, 25'd0, 8'h00, 8'h01));
        script.push_back(step_row(MODE_STATUS, 24'h000000, 25'd0, 8'h00, 8'hFE));
        script.push_back(step_row(MODE_BEGIN_PROG, 24'h0000FE, 25'd3, 8'h00, 8'h00));
        script.push_back(step_row(MODE_READ_BYTE, 24'h000000, 25'd0, 8'h00, 8'h00, 1, REJECT));
        script.push_back(step_row(MODE_STATUS, 24'h000000, 25'd0, 8'h00, 8'h00));
        script.push_back(step_row(MODE_PROG_BYTE, 24'h000000, 25'd0, 8'h00, 8'h00));
        script.push_back(step_row(MODE_PROG_BYTE, 24'h000000, 25'd0, 8'hA5, 8'h00));
        script.push_back(step_row(MODE_STATUS, 24'h000000, 25'd0, 8'h00, 8'h03));
        script.push_back(step_row(MODE_STATUS, 24'h000000, 25'd0, 8'h00, 8'h00));
        script.push_back(step_row(MODE_PROG_BYTE, 24'h000000, 25'd0, 8'hFF, 8'h00));
        script.push_back(step_row(MODE_BEGIN_PROG, 24'hFFFFFF, 25'd1, 8'h00, 8'h00));
        script.push_back(step_row(MODE_STATUS, 24'h000000, 25'd0, 8'h00, 8'h00));
        script.push_back(step_row(MODE_PROG_BYTE, 24'h000000, 25'd0, 8'h5A, 8'h00));
        foreach (script[i])
            issue(script[i]);

        base = requests_sent;
        while (requests_sent - base < RANDOM_REQUESTS)
            issue(step_row_t'({next_request(1'b1), 3'd0, 56'h0}));

        // finish any open operation, then open a read with an oversized length
        while (flash_phase != PH_IDLE)
            issue(step_row_t'({next_request(1'b0), 3'd0, 56'h0}));
        issue(step_row(MODE_BEGIN_READ, 24'($urandom), 25'h1FF_FFFF, 8'h00, 8'h00));
        repeat (3) issue(step_row_t'({next_request(1'b0), 3'd0, 56'h0}));
        issue(step_row(MODE_BEGIN_ERASE, 24'h000000, 25'd0, 8'h00, 8'h00, 1, REJECT));
        req_valid <= 1'b0;

        while (due_frames.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Sent %0d requests (%0d rejected); %0d operations closed.",
                 requests_sent, requests_rejected, ops_finished);
        $display("Checked %0d SPI frames, %0d mismatches.", frames_checked, mismatches);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* spi_flash_command_sequencer.f */
+incdir+design
design/sfcs_pkg.sv
design/sfcs_queue.sv
design/sfcs_front.sv
design/sfcs_back.sv
design/spi_flash_command_sequencer.sv
design/sfcs_checker.sv
tb/spi_flash_command_sequencer_tb.sv
